// ===== sv/crt_pkg.sv =====
package crt_pkg;

    // Button codes as reported in the result
    localparam logic [2:0] BTN_RIGHT  = 3'd0;
    localparam logic [2:0] BTN_UP     = 3'd1;
    localparam logic [2:0] BTN_DOWN   = 3'd2;
    localparam logic [2:0] BTN_LEFT   = 3'd3;
    localparam logic [2:0] BTN_SELECT = 3'd4;
    localparam logic [2:0] BTN_NONE   = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_INITIAL_START = 3'd0;
    localparam logic [2:0] CFG_THRESH_RIGHT  = 3'd1;
    localparam logic [2:0] CFG_THRESH_UP     = 3'd2;
    localparam logic [2:0] CFG_THRESH_DOWN   = 3'd3;
    localparam logic [2:0] CFG_THRESH_LEFT   = 3'd4;
    localparam logic [2:0] CFG_THRESH_SELECT = 3'd5;

    // Threshold reset values
    localparam logic [9:0] THRESH_RIGHT_RST  = 10'd60;
    localparam logic [9:0] THRESH_UP_RST     = 10'd200;
    localparam logic [9:0] THRESH_DOWN_RST   = 10'd400;
    localparam logic [9:0] THRESH_LEFT_RST   = 10'd600;
    localparam logic [9:0] THRESH_SELECT_RST = 10'd800;

    localparam logic [1:0] CURSOR_MAX = 2'd3;

    // Depth of the queue between decoder and state update
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       req_type;
        logic [9:0] ladder_sample;
    } in_item_t;

    typedef struct packed {
        logic        counting;
        logic        relay_on;
        logic [15:0] start_value;
        logic [15:0] remaining;
        logic [1:0]  cursor;
        logic [2:0]  button;
    } out_item_t;

    // Decoded request as held in the queue
    typedef struct packed {
        logic       req_type;
        logic [2:0] button;
    } q_entry_t;

    // Configuration write as seen by the front and back parts
    typedef struct packed {
        logic       wr;
        logic [2:0] index;
        logic [9:0] data;
    } cfg_wr_t;

    // Weight of the digit under the cursor
    function automatic logic [15:0] digit_weight(input logic [1:0] cur);
        logic [15:0] w;
        case (cur)
            2'd0:    w = 16'd1000;
            2'd1:    w = 16'd100;
            2'd2:    w = 16'd10;
            default: w = 16'd1;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/countdown_relay_timer_top.sv =====
// Countdown relay timer. Each request is a keypad ladder sample or a one-second
// tick, and each yields exactly one result with the timer state after it. The
// block takes one request per cycle while in_stall is low. The combinational
// threshold decoder writes each taken request into a two-entry queue, and the
// state update applies it and loads the result register. A stall on the result
// side fills the queue, after which in_stall rises. Write the
// thresholds and the start byte only while no request is in flight; writing
// initial_start also loads the edited start value.
module countdown_relay_timer_top #(
    parameter int QUEUE_DEPTH = crt_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  crt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output crt_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [9:0]         cfg_data
);

    crt_pkg::cfg_wr_t  cfg_wr;
    crt_pkg::q_entry_t push_entry;
    crt_pkg::q_entry_t q_head;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_not_empty;

    // Accept configuration writes at any time
    assign cfg_ready    = 1'b1;
    assign cfg_wr.wr    = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    crt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    crt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    crt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ===== sv/crt_front.sv =====
module crt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  crt_pkg::cfg_wr_t   cfg_wr,
    input  logic               in_valid,
    input  crt_pkg::in_item_t  in_data,
    input  logic               q_full,
    output logic               in_stall,
    output logic               push,
    output crt_pkg::q_entry_t  push_entry
);

    logic [9:0] th_right_reg;
    logic [9:0] th_up_reg;
    logic [9:0] th_down_reg;
    logic [9:0] th_left_reg;
    logic [9:0] th_select_reg;
    logic [2:0] button;

    // Hold the decode thresholds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_right_reg  <= crt_pkg::THRESH_RIGHT_RST;
            th_up_reg     <= crt_pkg::THRESH_UP_RST;
            th_down_reg   <= crt_pkg::THRESH_DOWN_RST;
            th_left_reg   <= crt_pkg::THRESH_LEFT_RST;
            th_select_reg <= crt_pkg::THRESH_SELECT_RST;
        end
        else if (cfg_wr.wr)
        begin
            case (cfg_wr.index)
                crt_pkg::CFG_THRESH_RIGHT:  th_right_reg  <= cfg_wr.data;
                crt_pkg::CFG_THRESH_UP:     th_up_reg     <= cfg_wr.data;
                crt_pkg::CFG_THRESH_DOWN:   th_down_reg   <= cfg_wr.data;
                crt_pkg::CFG_THRESH_LEFT:   th_left_reg   <= cfg_wr.data;
                crt_pkg::CFG_THRESH_SELECT: th_select_reg <= cfg_wr.data;
                default: ;
            endcase
        end
    end

    // Decode the ladder sample, first threshold below wins
    always_comb
    begin
        if (in_data.ladder_sample < th_right_reg)
            button = crt_pkg::BTN_RIGHT;
        else if (in_data.ladder_sample < th_up_reg)
            button = crt_pkg::BTN_UP;
        else if (in_data.ladder_sample < th_down_reg)
            button = crt_pkg::BTN_DOWN;
        else if (in_data.ladder_sample < th_left_reg)
            button = crt_pkg::BTN_LEFT;
        else if (in_data.ladder_sample < th_select_reg)
            button = crt_pkg::BTN_SELECT;
        else
            button = crt_pkg::BTN_NONE;
    end

    // Ticks carry no button
    assign in_stall            = q_full;
    assign push                = in_valid && !q_full;
    assign push_entry.req_type = in_data.req_type;
    assign push_entry.button   = in_data.req_type ? crt_pkg::BTN_NONE : button;

endmodule

// ===== sv/crt_queue.sv =====
module crt_queue #(
    parameter int DEPTH = crt_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  crt_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output crt_pkg::q_entry_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    crt_pkg::q_entry_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    property p_no_overflow;
        @(posedge clk) disable iff (!rst_n) full |-> !push;
    endproperty
    a_no_overflow: assert property (p_no_overflow)
        else $error("queue written while full");

    property p_no_underflow;
        @(posedge clk) disable iff (!rst_n) !not_empty |-> !pop;
    endproperty
    a_no_underflow: assert property (p_no_underflow)
        else $error("queue read while empty");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n) count_reg <= FULL_COUNT;
    endproperty
    a_count_bound: assert property (p_count_bound)
        else $error("queue fill count beyond depth");

endmodule

// ===== sv/crt_back.sv =====
module crt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  crt_pkg::cfg_wr_t   cfg_wr,
    input  logic               q_not_empty,
    input  crt_pkg::q_entry_t  q_head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output crt_pkg::out_item_t out_data
);

    logic        mode_reg, mode_next;
    logic        relay_reg, relay_next;
    logic [2:0]  prev_reg, prev_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] secs_reg, secs_next;
    logic [1:0]  cursor_reg, cursor_next;
    logic        valid_reg;
    crt_pkg::out_item_t data_reg, data_next;
    logic        is_new;
    logic [15:0] secs_dec;

    // Take the next request when the result register is free or being taken
    assign pop      = q_not_empty && (!valid_reg || !out_stall);
    assign is_new   = (prev_reg == crt_pkg::BTN_NONE);
    assign secs_dec = secs_reg - 16'd1;

    // Apply one request to the timer state
    always_comb
    begin
        mode_next   = mode_reg;
        relay_next  = relay_reg;
        prev_next   = prev_reg;
        start_next  = start_reg;
        secs_next   = secs_reg;
        cursor_next = cursor_reg;
        if (q_head.req_type)
        begin
            if (mode_reg)
            begin
                secs_next = secs_dec;
                if (secs_dec == 16'd0)
                begin
                    mode_next  = 1'b0;
                    relay_next = 1'b0;
                end
            end
        end
        else
        begin
            prev_next = q_head.button;
            if (is_new)
            begin
                case (q_head.button)
                    crt_pkg::BTN_RIGHT:
                        if (!mode_reg && cursor_reg != crt_pkg::CURSOR_MAX)
                            cursor_next = cursor_reg + 2'd1;
                    crt_pkg::BTN_LEFT:
                        if (!mode_reg && cursor_reg != 2'd0)
                            cursor_next = cursor_reg - 2'd1;
                    crt_pkg::BTN_UP:
                        if (!mode_reg)
                            start_next = start_reg + crt_pkg::digit_weight(cursor_reg);
                    crt_pkg::BTN_DOWN:
                        if (!mode_reg)
                            start_next = start_reg - crt_pkg::digit_weight(cursor_reg);
                    crt_pkg::BTN_SELECT:
                        if (!mode_reg)
                        begin
                            mode_next  = 1'b1;
                            relay_next = 1'b1;
                            secs_next  = start_reg;
                        end
                        else
                        begin
                            mode_next  = 1'b0;
                            relay_next = 1'b0;
                        end
                    default: ;
                endcase
            end
        end
        data_next.counting    = mode_next;
        data_next.relay_on    = relay_next;
        data_next.start_value = start_next;
        data_next.remaining   = mode_next ? secs_next : 16'd0;
        data_next.cursor      = cursor_next;
        data_next.button      = q_head.button;
    end

    // Hold the timer state; a start value write loads the written byte when no request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            relay_reg  <= 1'b0;
            prev_reg   <= crt_pkg::BTN_NONE;
            start_reg  <= '0;
            secs_reg   <= '0;
            cursor_reg <= '0;
        end
        else if (pop)
        begin
            mode_reg   <= mode_next;
            relay_reg  <= relay_next;
            prev_reg   <= prev_next;
            start_reg  <= start_next;
            secs_reg   <= secs_next;
            cursor_reg <= cursor_next;
        end
        else if (cfg_wr.wr && cfg_wr.index == crt_pkg::CFG_INITIAL_START)
        begin
            start_reg <= {8'd0, cfg_wr.data[7:0]};
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    property p_relay_follows_mode;
        @(posedge clk) disable iff (!rst_n) relay_reg == mode_reg;
    endproperty
    a_relay_follows_mode: assert property (p_relay_follows_mode)
        else $error("relay out of step with counting mode");

    property p_remaining_editing;
        @(posedge clk) disable iff (!rst_n)
            (valid_reg && !data_reg.counting) |-> (data_reg.remaining == 16'd0);
    endproperty
    a_remaining_editing: assert property (p_remaining_editing)
        else $error("remaining non-zero while editing");

    property p_tick_keeps_prev;
        @(posedge clk) disable iff (!rst_n)
            (pop && q_head.req_type) |=> $stable(prev_reg);
    endproperty
    a_tick_keeps_prev: assert property (p_tick_keeps_prev)
        else $error("tick changed the previous button");

    property p_tick_reports_none;
        @(posedge clk) disable iff (!rst_n)
            (pop && q_head.req_type) |=> (data_reg.button == crt_pkg::BTN_NONE);
    endproperty
    a_tick_reports_none: assert property (p_tick_reports_none)
        else $error("tick result carries a button");

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Keypad readings that decode to each button under the reset thresholds
    localparam logic [9:0] KEY_RIGHT  = 10'd0;
    localparam logic [9:0] KEY_UP     = 10'd100;
    localparam logic [9:0] KEY_DOWN   = 10'd300;
    localparam logic [9:0] KEY_LEFT   = 10'd500;
    localparam logic [9:0] KEY_SELECT = 10'd700;
    localparam logic [9:0] KEY_NONE   = 10'd1023;

    localparam int RANDOM_PHASES    = 17;
    localparam int ITEMS_PER_PHASE  = 100;
    localparam int DRAIN_LIMIT      = 4000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    crt_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    crt_pkg::out_item_t out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [9:0]         cfg_data = '0;

    // Timer status expected for each request still in flight
    crt_pkg::out_item_t status_due[$];
    int        fail_count = 0;
    bit        sender_idle = 1'b1;
    bit        sink_idle = 1'b1;

    // Own copy of the timer state and its settings
    logic       tm_counting;
    logic [2:0] tm_prev_btn;
    logic [15:0] tm_start;
    logic [15:0] tm_left;
    logic [1:0] tm_cursor;
    logic       tm_relay;
    logic [9:0] thr_right, thr_up, thr_down, thr_left, thr_select;

    countdown_relay_timer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        fail_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            note_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    function automatic int draw_wait(input bit enabled);
        if (!enabled || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic reset_timer_model();
        tm_counting  = 1'b0;
        tm_prev_btn  = crt_pkg::BTN_NONE;
        tm_start     = 16'd0;
        tm_left      = 16'd0;
        tm_cursor    = 2'd0;
        tm_relay     = 1'b0;
        thr_right    = crt_pkg::THRESH_RIGHT_RST;
        thr_up       = crt_pkg::THRESH_UP_RST;
        thr_down     = crt_pkg::THRESH_DOWN_RST;
        thr_left     = crt_pkg::THRESH_LEFT_RST;
        thr_select   = crt_pkg::THRESH_SELECT_RST;
    endtask

    // First threshold the reading falls below wins, whatever their order
    function automatic logic [2:0] classify_sample(input logic [9:0] s);
        if (s < thr_right)  return crt_pkg::BTN_RIGHT;
        if (s < thr_up)     return crt_pkg::BTN_UP;
        if (s < thr_down)   return crt_pkg::BTN_DOWN;
        if (s < thr_left)   return crt_pkg::BTN_LEFT;
        if (s < thr_select) return crt_pkg::BTN_SELECT;
        return crt_pkg::BTN_NONE;
    endfunction

    // Advance the timer by one request and give the status that follows
    task automatic step_timer(input crt_pkg::in_item_t rq, output crt_pkg::out_item_t st);
        logic [2:0]  btn;
        logic [15:0] weight;
        btn = crt_pkg::BTN_NONE;
        case (tm_cursor)
            2'd0:    weight = 16'd1000;
            2'd1:    weight = 16'd100;
            2'd2:    weight = 16'd10;
            default: weight = 16'd1;
        endcase
        if (rq.req_type)
        begin
            // count down; zero drops the relay, counting from zero wraps
            if (tm_counting)
            begin
                tm_left = tm_left - 16'd1;
                if (tm_left == 16'd0)
                begin
                    tm_counting = 1'b0;
                    tm_relay    = 1'b0;
                end
            end
        end
        else
        begin
            btn = classify_sample(rq.ladder_sample);
            // act only on a fresh press
            if (tm_prev_btn == crt_pkg::BTN_NONE)
            begin
                case (btn)
                    crt_pkg::BTN_RIGHT:
                        if (!tm_counting && tm_cursor != crt_pkg::CURSOR_MAX)
                            tm_cursor = tm_cursor + 2'd1;
                    crt_pkg::BTN_LEFT:
                        if (!tm_counting && tm_cursor != 2'd0)
                            tm_cursor = tm_cursor - 2'd1;
                    crt_pkg::BTN_UP:
                        if (!tm_counting)
                            tm_start = tm_start + weight;
                    crt_pkg::BTN_DOWN:
                        if (!tm_counting)
                            tm_start = tm_start - weight;
                    crt_pkg::BTN_SELECT:
                        if (!tm_counting)
                        begin
                            tm_counting = 1'b1;
                            tm_left     = tm_start;
                            tm_relay    = 1'b1;
                        end
                        else
                        begin
                            tm_counting = 1'b0;
                            tm_relay    = 1'b0;
                        end
                    default: ;
                endcase
            end
            tm_prev_btn = btn;
        end
        st.counting    = tm_counting;
        st.relay_on    = tm_relay;
        st.start_value = tm_start;
        st.remaining   = tm_counting ? tm_left : 16'd0;
        st.cursor      = tm_cursor;
        st.button      = btn;
    endtask

    // Offer one request, hold it through stalls, predict once taken
    task automatic send_request(input crt_pkg::in_item_t rq);
        int                 gap;
        crt_pkg::out_item_t st;
        gap = draw_wait(sender_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        do @(posedge clk); while (in_stall);
        step_timer(rq, st);
        status_due.push_back(st);
        @(negedge clk);
    endtask

    task automatic press(input logic [9:0] s);
        send_request(crt_pkg::in_item_t'{1'b0, s});
    endtask

    task automatic tick();
        send_request(crt_pkg::in_item_t'{1'b1, 10'($urandom_range(0, 1023))});
    endtask

    // Register write; only issued with nothing in flight
    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            crt_pkg::CFG_INITIAL_START: tm_start   = {8'h00, val[7:0]};
            crt_pkg::CFG_THRESH_RIGHT:  thr_right  = val;
            crt_pkg::CFG_THRESH_UP:     thr_up     = val;
            crt_pkg::CFG_THRESH_DOWN:   thr_down   = val;
            crt_pkg::CFG_THRESH_LEFT:   thr_left   = val;
            crt_pkg::CFG_THRESH_SELECT: thr_select = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Hold off new requests until every status has come back
    task automatic drain_results();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (status_due.size() != 0 && waited < DRAIN_LIMIT);
        if (status_due.size() != 0)
        begin
            note_mismatch($sformatf("%0d status results never arrived", status_due.size()));
            status_due.delete();
        end
    endtask

    // Reading inside the band of button b under the current thresholds
    function automatic logic [9:0] sample_for(input logic [2:0] b);
        int th[5];
        int lo;
        int hi;
        th = '{int'(thr_right), int'(thr_up), int'(thr_down), int'(thr_left),
               int'(thr_select)};
        lo = 0;
        for (int k = 0; k < int'(b) && k < 5; k++)
            if (th[k] > lo)
                lo = th[k];
        hi = (b == crt_pkg::BTN_NONE) ? 1023 : th[b] - 1;
        if (lo <= hi)
            return 10'($urandom_range(lo, hi));
        return 10'($urandom_range(0, 1023));
    endfunction

    // Mostly press-and-release sequences, some ticks, a little noise
    function automatic crt_pkg::in_item_t pick_request();
        int         r;
        logic [2:0] b;
        r = $urandom_range(0, 99);
        if (r < 8)
            return crt_pkg::in_item_t'(11'($urandom_range(0, 2047)));
        if (tm_prev_btn != crt_pkg::BTN_NONE && r < 80)
            return crt_pkg::in_item_t'{1'b0, sample_for(crt_pkg::BTN_NONE)};
        r = $urandom_range(0, 99);
        if (tm_counting)
        begin
            if (r < 60)
                return crt_pkg::in_item_t'{1'b1, 10'($urandom_range(0, 1023))};
            if (r < 72)
                b = crt_pkg::BTN_SELECT;
            else if (r < 88)
                b = 3'($urandom_range(0, 3));
            else
                b = crt_pkg::BTN_NONE;
        end
        else
        begin
            if (r < 12)
                return crt_pkg::in_item_t'{1'b1, 10'($urandom_range(0, 1023))};
            if (r < 24)
                b = crt_pkg::BTN_SELECT;
            else if (r < 86)
                b = 3'($urandom_range(0, 3));
            else
                b = crt_pkg::BTN_NONE;
        end
        return crt_pkg::in_item_t'{1'b0, sample_for(b)};
    endfunction

    // Settings for one random phase: reset values, both extremes, or random ones, sorted in even phases
    task automatic load_phase_settings(input int ph);
        int         t[$];
        logic [9:0] start_word;
        t.delete();
        start_word = 10'(($urandom_range(0, 3) << 8) |
                         ($urandom_range(0, 4) == 0 ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 30)));
        if (ph == 1)
        begin
            start_word = 10'h3FF;
            repeat (5) t.push_back(0);
        end
        else if (ph == 2)
        begin
            start_word = 10'd0;
            repeat (5) t.push_back(1023);
        end
        else if (ph == 0 || ph == 3)
        begin
            t = '{int'(crt_pkg::THRESH_RIGHT_RST), int'(crt_pkg::THRESH_UP_RST),
                  int'(crt_pkg::THRESH_DOWN_RST), int'(crt_pkg::THRESH_LEFT_RST),
                  int'(crt_pkg::THRESH_SELECT_RST)};
        end
        else
        begin
            repeat (5) t.push_back($urandom_range(0, 1023));
            if (ph % 2 == 0)
                t.sort();
        end
        write_reg(crt_pkg::CFG_INITIAL_START, start_word);
        write_reg(crt_pkg::CFG_THRESH_RIGHT,  10'(t[0]));
        write_reg(crt_pkg::CFG_THRESH_UP,     10'(t[1]));
        write_reg(crt_pkg::CFG_THRESH_DOWN,   10'(t[2]));
        write_reg(crt_pkg::CFG_THRESH_LEFT,   10'(t[3]));
        write_reg(crt_pkg::CFG_THRESH_SELECT, 10'(t[4]));
    endtask

    // Editing keys under reset settings: clamps, held key, wrap, ignored keys
    task automatic test_editing_keys();
        tick();
        press(KEY_NONE);
        press(KEY_LEFT);
        press(KEY_LEFT);
        press(KEY_NONE);
        press(KEY_DOWN);
        press(KEY_NONE);
        press(KEY_RIGHT);
        press(KEY_NONE);
        press(KEY_UP);
        press(KEY_NONE);
        repeat (3)
        begin
            press(KEY_RIGHT);
            press(KEY_NONE);
        end
        press(KEY_SELECT);
        press(KEY_UP);
        press(KEY_NONE);
        tick();
        press(KEY_SELECT);
        press(KEY_NONE);
    endtask

    // Count down to zero, then start from zero and let it wrap
    task automatic test_countdown_ends();
        drain_results();
        write_reg(crt_pkg::CFG_INITIAL_START, 10'd1);
        press(KEY_SELECT);
        tick();
        press(KEY_NONE);
        drain_results();
        write_reg(crt_pkg::CFG_INITIAL_START, 10'd0);
        press(KEY_SELECT);
        tick();
        press(KEY_NONE);
        press(KEY_SELECT);
        press(KEY_NONE);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_results();
            sender_idle = (ph % 3 != 1);
            sink_idle   = (ph % 4 != 2);
            load_phase_settings(ph);
            repeat (ITEMS_PER_PHASE)
                send_request(pick_request());
        end
    endtask

    // Compare each status taken from the block with the oldest prediction
    always @(posedge clk)
    begin : check_status
        crt_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (status_due.size() == 0)
            begin
                note_mismatch("status result with no request outstanding");
            end
            else
            begin
                want = status_due.pop_front();
                compare_field("counting",    int'(out_data.counting),
                              int'(want.counting));
                compare_field("relay_on",    int'(out_data.relay_on),
                              int'(want.relay_on));
                compare_field("start_value", int'(out_data.start_value),
                              int'(want.start_value));
                compare_field("remaining",   int'(out_data.remaining),
                              int'(want.remaining));
                compare_field("cursor",      int'(out_data.cursor),
                              int'(want.cursor));
                compare_field("button",      int'(out_data.button),
                              int'(want.button));
            end
        end
    end

    // Result side: stall a random while before taking each status
    initial
    begin
        int hold;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            hold = draw_wait(sink_idle);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial
    begin
        reset_timer_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_editing_keys();
        test_countdown_ends();
        test_random_phases();
        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("** countdown_relay_timer_top: PASSED **");
        else
            $display("** countdown_relay_timer_top: FAILED **");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #10_000_000;
        $display("** countdown_relay_timer_top: FAILED **");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/crt_pkg.sv
sv/crt_front.sv
sv/crt_queue.sv
sv/crt_back.sv
sv/countdown_relay_timer_top.sv
sim/tb_top.sv
